// ----- rtl/core/pce_pkg.sv -----
// pce_pkg: shared types and constants of the configuration space enumerator
// used by the sequencer, the result queue, the top level and the checker
`default_nettype none

package pce_pkg;

    localparam int DEVICE_LIMIT = 64;
    localparam int BUS_COUNT    = 256;

    // input beat modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_CPL   = 1'b1;

    // result kinds
    localparam logic [2:0] KIND_REQ = 3'd0;
    localparam logic [2:0] KIND_DEV = 3'd1;
    localparam logic [2:0] KIND_BAR = 3'd2;
    localparam logic [2:0] KIND_OK  = 3'd3;
    localparam logic [2:0] KIND_OVF = 3'd4;

    // configuration register byte offsets
    localparam logic [7:0] OFF_ID    = 8'd0;
    localparam logic [7:0] OFF_CLASS = 8'd8;
    localparam logic [7:0] OFF_HDR   = 8'd12;
    localparam logic [7:0] OFF_BAR0  = 8'd16;

    localparam logic [15:0] VENDOR_ABSENT = 16'hffff;

    typedef struct packed {
        logic        mode;
        logic [31:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  function_res;
        logic [7:0]  offset;
        logic [15:0] vend_id;
        logic [15:0] dev_ident;
        logic [7:0]  base_class;
        logic [7:0]  subclass;
        logic [7:0]  prog_interface;
        logic [7:0]  hdr_byte;
        logic [31:0] bar_value;
    } t_out_item;

    // results produced by one sequencer step, first beat first
    typedef struct packed {
        logic [1:0] num;
        t_out_item  first;
        t_out_item  second;
    } t_push;

endpackage

`default_nettype wire

// ----- rtl/core/pce_seq.sv -----
// pce_seq: input register, scan state and the combinational step logic
// depends on pce_pkg; hands zero, one or two results to the result queue
`default_nettype none

module pce_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire pce_pkg::t_in_item i_in,
    input  wire logic           i_room,
    output pce_pkg::t_push      o_push
);
    import pce_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_PROBE = 7'b0000010,
        PH_HDR0  = 7'b0000100,
        PH_ID    = 7'b0001000,
        PH_CLASS = 7'b0010000,
        PH_HDR   = 7'b0100000,
        PH_BAR   = 7'b1000000
    } t_phase;

    logic        r_in_vld;
    t_in_item    r_in;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_bus, n_bus;
    logic [4:0]  r_slot, n_slot;
    logic [2:0]  r_fn, n_fn;
    logic [3:0]  r_ftot, n_ftot;
    logic [2:0]  r_bar_idx, n_bar_idx;
    logic [2:0]  r_bar_tot, n_bar_tot;
    logic [6:0]  r_dev_cnt, n_dev_cnt;
    logic [31:0] r_saved_id, n_saved_id;
    logic [31:0] r_saved_class, n_saved_class;

    logic        fire;
    logic        absent;
    logic        adv_fn, adv_slot;
    logic        has_rec, has_tail;
    logic [2:0]  tail_kind;
    logic [7:0]  ht;
    logic [7:0]  req_off;
    t_out_item   rec, tail;

    assign fire       = r_in_vld && i_room;
    assign o_in_stall = r_in_vld && !i_room;
    assign absent     = (r_in.read_data[15:0] == VENDOR_ABSENT);
    assign ht         = r_in.read_data[23:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= PH_IDLE;
            r_bus     <= '0;
            r_slot    <= '0;
            r_fn      <= '0;
            r_ftot    <= 4'd1;
            r_bar_idx <= '0;
            r_bar_tot <= '0;
            r_dev_cnt <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            r_phase   <= n_phase;
            r_bus     <= n_bus;
            r_slot    <= n_slot;
            r_fn      <= n_fn;
            r_ftot    <= n_ftot;
            r_bar_idx <= n_bar_idx;
            r_bar_tot <= n_bar_tot;
            r_dev_cnt <= n_dev_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
        r_saved_id    <= n_saved_id;
        r_saved_class <= n_saved_class;
    end

    always_comb begin
        n_phase       = r_phase;
        n_bus         = r_bus;
        n_slot        = r_slot;
        n_fn          = r_fn;
        n_ftot        = r_ftot;
        n_bar_idx     = r_bar_idx;
        n_bar_tot     = r_bar_tot;
        n_dev_cnt     = r_dev_cnt;
        n_saved_id    = r_saved_id;
        n_saved_class = r_saved_class;
        adv_fn        = 1'b0;
        adv_slot      = 1'b0;
        has_rec       = 1'b0;
        has_tail      = 1'b0;
        tail_kind     = KIND_REQ;
        rec           = '0;

        if (fire) begin
            if (r_in.mode == MODE_START) begin
                n_bus     = '0;
                n_slot    = '0;
                n_fn      = '0;
                n_ftot    = 4'd1;
                n_bar_idx = '0;
                n_bar_tot = '0;
                n_dev_cnt = '0;
                n_phase   = PH_PROBE;
                has_tail  = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_PROBE: begin
                        has_tail = 1'b1;
                        if (absent) begin
                            adv_slot = 1'b1;
                        end else begin
                            n_phase = PH_HDR0;
                        end
                    end
                    PH_HDR0: begin
                        has_tail = 1'b1;
                        n_ftot   = r_in.read_data[23] ? 4'd8 : 4'd1;
                        n_fn     = '0;
                        n_phase  = PH_ID;
                    end
                    PH_ID: begin
                        has_tail = 1'b1;
                        if (absent) begin
                            adv_fn = 1'b1;
                        end else if ({1'b0, r_dev_cnt} >= 8'(DEVICE_LIMIT)) begin
                            n_phase   = PH_IDLE;
                            tail_kind = KIND_OVF;
                        end else begin
                            n_saved_id = r_in.read_data;
                            n_phase    = PH_CLASS;
                        end
                    end
                    PH_CLASS: begin
                        has_tail      = 1'b1;
                        n_saved_class = r_in.read_data;
                        n_phase       = PH_HDR;
                    end
                    PH_HDR: begin
                        has_rec            = 1'b1;
                        has_tail           = 1'b1;
                        rec.kind           = KIND_DEV;
                        rec.bus            = r_bus;
                        rec.slot           = r_slot;
                        rec.function_res   = r_fn;
                        rec.vend_id        = r_saved_id[15:0];
                        rec.dev_ident      = r_saved_id[31:16];
                        rec.base_class     = r_saved_class[31:24];
                        rec.subclass       = r_saved_class[23:16];
                        rec.prog_interface = r_saved_class[15:8];
                        rec.hdr_byte       = ht;
                        n_dev_cnt          = r_dev_cnt + 7'd1;
                        n_bar_idx          = '0;
                        if (ht[6:0] == 7'd0) begin
                            n_bar_tot = 3'd6;
                        end else if (ht[6:0] == 7'd1) begin
                            n_bar_tot = 3'd2;
                        end else begin
                            n_bar_tot = 3'd0;
                        end
                        if (n_bar_tot != 3'd0) begin
                            n_phase = PH_BAR;
                        end else begin
                            adv_fn = 1'b1;
                        end
                    end
                    PH_BAR: begin
                        has_rec          = 1'b1;
                        has_tail         = 1'b1;
                        rec.kind         = KIND_BAR;
                        rec.bus          = r_bus;
                        rec.slot         = r_slot;
                        rec.function_res = r_fn;
                        rec.offset       = OFF_BAR0 + {3'b000, r_bar_idx, 2'b00};
                        rec.bar_value    = r_in.read_data;
                        n_bar_idx        = r_bar_idx + 3'd1;
                        if (n_bar_idx >= r_bar_tot) begin
                            adv_fn = 1'b1;
                        end
                    end
                    PH_IDLE: begin
                    end
                    default: begin
                        // stray phase code behaves as idle
                    end
                endcase
            end

            if (adv_fn) begin
                if ({1'b0, r_fn} + 4'd1 < r_ftot) begin
                    n_fn    = r_fn + 3'd1;
                    n_phase = PH_ID;
                end else begin
                    adv_slot = 1'b1;
                end
            end

            if (adv_slot) begin
                n_fn   = '0;
                n_ftot = 4'd1;
                if (r_slot != 5'd31) begin
                    n_slot  = r_slot + 5'd1;
                    n_phase = PH_PROBE;
                end else begin
                    n_slot = '0;
                    if ({1'b0, r_bus} + 9'd1 < 9'(BUS_COUNT)) begin
                        n_bus   = r_bus + 8'd1;
                        n_phase = PH_PROBE;
                    end else begin
                        n_bus     = '0;
                        n_phase   = PH_IDLE;
                        tail_kind = KIND_OK;
                    end
                end
            end
        end
    end

    // next request is built from the updated location
    always_comb begin
        unique case (n_phase)
            PH_HDR0, PH_HDR: req_off = OFF_HDR;
            PH_CLASS:        req_off = OFF_CLASS;
            PH_BAR:          req_off = OFF_BAR0 + {3'b000, n_bar_idx, 2'b00};
            default:         req_off = OFF_ID;
        endcase
        tail = '0;
        if (tail_kind == KIND_REQ) begin
            tail.kind         = KIND_REQ;
            tail.bus          = n_bus;
            tail.slot         = n_slot;
            tail.function_res = n_fn;
            tail.offset       = req_off;
        end else begin
            tail.kind = tail_kind;
        end
    end

    always_comb begin
        o_push = '0;
        if (has_rec) begin
            o_push.num    = has_tail ? 2'd2 : 2'd1;
            o_push.first  = rec;
            o_push.second = tail;
        end else if (has_tail) begin
            o_push.num   = 2'd1;
            o_push.first = tail;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pce_rbuf.sv -----
// pce_rbuf: four-entry result queue, takes up to two beats per cycle, sends one
// unless the output stalls; depends on pce_pkg; room is offered while at most two entries are held
`default_nettype none

module pce_rbuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pce_pkg::t_push   i_push,
    output logic                  o_room,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output pce_pkg::t_out_item    o_out
);
    import pce_pkg::*;

    t_out_item  r_q [4];
    logic [1:0] r_head, n_head;
    logic [1:0] r_tail, n_tail;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign o_room      = (r_cnt <= 3'd2);
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out       = r_q[r_head];
    assign pop         = o_out_valid && !i_out_stall;

    always_comb begin
        n_head = pop ? r_head + 2'd1 : r_head;
        n_tail = r_tail + i_push.num;
        n_cnt  = r_cnt + {1'b0, i_push.num} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_q[r_tail] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_q[r_tail + 2'd1] <= i_push.second;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pci_config_enumerator_top.sv -----
// configuration space enumerator, one configuration read per completion beat
// an accepted beat is held in the input register, its results then in the queue
// throughput: one input beat per cycle into the step logic while the queue has room;
//   results leave one per cycle from a four-entry queue unless the output stalls
// reset: synchronous active low, scan idle, queue empty, no result pending
`default_nettype none

module pci_config_enumerator_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire pce_pkg::t_in_item   i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output pce_pkg::t_out_item       o_out
);
    import pce_pkg::*;

    t_push push;
    logic  room;

    pce_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_room     (room),
        .o_push     (push)
    );

    pce_rbuf u_rbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ----- rtl/core/pce_checker.sv -----
// pce_checker: port-level assertions for the enumerator top level
// depends on pce_pkg; attached to pci_config_enumerator_top by the bind below
`default_nettype none

module pce_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire pce_pkg::t_in_item  i_in,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire pce_pkg::t_out_item o_out
);
    import pce_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result beat changed under stall");

    // done beats carry no location
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == KIND_OK || o_out.kind == KIND_OVF)
        |-> o_out.bus == 8'd0 && o_out.slot == 5'd0 && o_out.offset == 8'd0)
        else $error("done beat with location");

    // requests only target id, class, header or a bar dword
    a_req_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind == KIND_REQ
        |-> o_out.offset[1:0] == 2'b00 && o_out.offset <= 8'd36
            && o_out.bar_value == 32'd0)
        else $error("bad request offset");

    // nothing leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output after reset");

    // with the input side idle in the previous cycle, an empty output stays empty
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && $past(!i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result without an earlier beat");

endmodule

bind pci_config_enumerator_top pce_checker u_pce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

// ----- dv/tb_pci_config_enumerator_top.sv -----
// testbench of the configuration space enumerator: drives start and completion beats,
// predicts every read request, device record, bar word and done beat, and checks them
// depends on pce_pkg and pci_config_enumerator_top
`timescale 1ns / 100ps

module tb_pci_config_enumerator_top;

    import pce_pkg::*;

    localparam int GAP_MAX        = 19;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int NOISE_PCT      = 8;
    localparam int RESTART_PCT    = 2;

    localparam logic [6:0] HDR_TYPE_DEVICE = 7'd0;
    localparam logic [6:0] HDR_TYPE_BRIDGE = 7'd1;
    localparam logic [2:0] DEVICE_BARS     = 3'd6;
    localparam logic [2:0] BRIDGE_BARS     = 3'd2;
    localparam logic [3:0] MULTI_FUNCS     = 4'd8;
    localparam logic [4:0] LAST_SLOT       = 5'd31;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_PROBE,
        SCAN_HDR0,
        SCAN_ID,
        SCAN_CLASS,
        SCAN_HDR,
        SCAN_BAR
    } t_scan_phase;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;

    // predicted scan state
    t_scan_phase scan_phase;
    logic [7:0]  cur_bus;
    logic [4:0]  cur_slot;
    logic [2:0]  cur_func;
    logic [3:0]  func_total;
    logic [2:0]  bar_idx;
    logic [2:0]  bar_cnt;
    logic [6:0]  dev_count;
    logic [31:0] id_word;
    logic [31:0] class_word;

    t_out_item expected_beats[$];
    int        mismatch_cnt;
    int        idle_cycles;
    logic      quiet_mode;

    pci_config_enumerator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void scan_clear();
        cur_bus    = '0;
        cur_slot   = '0;
        cur_func   = '0;
        func_total = 4'd1;
        bar_idx    = '0;
        bar_cnt    = '0;
        dev_count  = '0;
    endfunction

    function automatic t_out_item loc_beat(logic [2:0] kind, logic [7:0] off);
        t_out_item b;
        b              = '0;
        b.kind         = kind;
        b.bus          = cur_bus;
        b.slot         = cur_slot;
        b.function_res = cur_func;
        b.offset       = off;
        return b;
    endfunction

    function automatic t_out_item done_beat(logic [2:0] kind);
        t_out_item b;
        b      = '0;
        b.kind = kind;
        return b;
    endfunction

    function automatic t_out_item request_beat();
        logic [7:0] off;
        case (scan_phase)
            SCAN_HDR0, SCAN_HDR: off = OFF_HDR;
            SCAN_CLASS:          off = OFF_CLASS;
            SCAN_BAR:            off = OFF_BAR0 + {3'b000, bar_idx, 2'b00};
            default:             off = OFF_ID;
        endcase
        return loc_beat(KIND_REQ, off);
    endfunction

    function automatic t_out_item next_slot();
        cur_func   = '0;
        func_total = 4'd1;
        if (cur_slot < LAST_SLOT) begin
            cur_slot   = cur_slot + 5'd1;
            scan_phase = SCAN_PROBE;
            return request_beat();
        end
        cur_slot = '0;
        if (int'(cur_bus) + 1 < BUS_COUNT) begin
            cur_bus    = cur_bus + 8'd1;
            scan_phase = SCAN_PROBE;
            return request_beat();
        end
        cur_bus    = '0;
        scan_phase = SCAN_IDLE;
        return done_beat(KIND_OK);
    endfunction

    function automatic t_out_item next_function();
        if ({1'b0, cur_func} + 4'd1 < func_total) begin
            cur_func   = cur_func + 3'd1;
            scan_phase = SCAN_ID;
            return request_beat();
        end
        return next_slot();
    endfunction

    // one accepted input beat: advance the scan and queue the beats it yields
    function automatic void enumerate_step(t_in_item it);
        t_out_item  rec;
        logic [7:0] ht;
        if (it.mode == MODE_START) begin
            scan_clear();
            scan_phase = SCAN_PROBE;
            expected_beats.push_back(request_beat());
            return;
        end
        case (scan_phase)
            SCAN_PROBE: begin
                if (it.read_data[15:0] == VENDOR_ABSENT) begin
                    expected_beats.push_back(next_slot());
                end else begin
                    scan_phase = SCAN_HDR0;
                    expected_beats.push_back(request_beat());
                end
            end
            SCAN_HDR0: begin
                func_total = it.read_data[23] ? MULTI_FUNCS : 4'd1;
                cur_func   = '0;
                scan_phase = SCAN_ID;
                expected_beats.push_back(request_beat());
            end
            SCAN_ID: begin
                if (it.read_data[15:0] == VENDOR_ABSENT) begin
                    expected_beats.push_back(next_function());
                end else if (dev_count >= DEVICE_LIMIT) begin
                    scan_phase = SCAN_IDLE;
                    expected_beats.push_back(done_beat(KIND_OVF));
                end else begin
                    id_word    = it.read_data;
                    scan_phase = SCAN_CLASS;
                    expected_beats.push_back(request_beat());
                end
            end
            SCAN_CLASS: begin
                class_word = it.read_data;
                scan_phase = SCAN_HDR;
                expected_beats.push_back(request_beat());
            end
            SCAN_HDR: begin
                ht                 = it.read_data[23:16];
                rec                = loc_beat(KIND_DEV, '0);
                rec.vend_id        = id_word[15:0];
                rec.dev_ident      = id_word[31:16];
                rec.base_class     = class_word[31:24];
                rec.subclass       = class_word[23:16];
                rec.prog_interface = class_word[15:8];
                rec.hdr_byte       = ht;
                expected_beats.push_back(rec);
                dev_count = dev_count + 7'd1;
                if (ht[6:0] == HDR_TYPE_DEVICE)      bar_cnt = DEVICE_BARS;
                else if (ht[6:0] == HDR_TYPE_BRIDGE) bar_cnt = BRIDGE_BARS;
                else                                 bar_cnt = '0;
                bar_idx = '0;
                if (bar_cnt != '0) begin
                    scan_phase = SCAN_BAR;
                    expected_beats.push_back(request_beat());
                end else begin
                    expected_beats.push_back(next_function());
                end
            end
            SCAN_BAR: begin
                rec           = loc_beat(KIND_BAR, OFF_BAR0 + {3'b000, bar_idx, 2'b00});
                rec.bar_value = it.read_data;
                expected_beats.push_back(rec);
                bar_idx = bar_idx + 3'd1;
                if (bar_idx < bar_cnt) expected_beats.push_back(request_beat());
                else                   expected_beats.push_back(next_function());
            end
            default: ;
        endcase
    endfunction

    // completion dword that fits the pending read, now and then pure noise
    function automatic logic [31:0] scan_reply(int unsigned absent_pct, int unsigned noise_pct);
        logic [31:0] d;
        int unsigned sel;
        d = $urandom;
        if ($urandom_range(0, 99) < noise_pct) return d;
        case (scan_phase)
            SCAN_PROBE, SCAN_ID: begin
                if ($urandom_range(0, 99) < absent_pct) d[15:0] = VENDOR_ABSENT;
                else if (d[15:0] == VENDOR_ABSENT)      d[0] = 1'b0;
            end
            SCAN_HDR: begin
                sel = $urandom_range(0, 9);
                if (sel < 4)      d[22:16] = HDR_TYPE_DEVICE;
                else if (sel < 7) d[22:16] = HDR_TYPE_BRIDGE;
            end
            default: ;
        endcase
        return d;
    endfunction

    // one input beat; valid stays up afterwards so back to back beats need no gap
    task automatic send_beat(input logic mode, input logic [31:0] data);
        int unsigned gap;
        gap = quiet_mode ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in.mode      = mode;
        i_in.read_data = data;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        enumerate_step(i_in);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // completions while idle are dropped and yield no result
    task automatic test_idle_completion();
        send_beat(MODE_CPL, 32'h0000_0000);
        send_beat(MODE_CPL, 32'hffff_ffff);
        drain_results();
    endtask

    // single function type 0 device, restart mid scan, multifunction slot
    task automatic test_device_walk();
        send_beat(MODE_START, 32'h0000_0000);
        send_beat(MODE_CPL, 32'hffff_0000);
        send_beat(MODE_CPL, 32'h0000_0000);
        send_beat(MODE_CPL, 32'h1234_abcd);
        send_beat(MODE_CPL, 32'hffff_ffff);
        send_beat(MODE_CPL, 32'hff00_ffff);
        send_beat(MODE_CPL, 32'h0000_0000);
        send_beat(MODE_CPL, 32'hffff_ffff);
        for (int i = 0; i < 4; i++) send_beat(MODE_CPL, $urandom);
        send_beat(MODE_CPL, 32'h0000_ffff);
        send_beat(MODE_START, 32'hffff_ffff);
        send_beat(MODE_CPL, 32'h0001_0001);
        send_beat(MODE_CPL, 32'h0080_0000);
        send_beat(MODE_CPL, 32'hfffe_fffe);
        send_beat(MODE_CPL, 32'h0000_0000);
        send_beat(MODE_CPL, 32'h0081_0000);
        send_beat(MODE_CPL, 32'haaaa_5555);
        send_beat(MODE_CPL, 32'h5555_aaaa);
        send_beat(MODE_CPL, 32'h0000_ffff);
        send_beat(MODE_CPL, 32'h0000_0000);
        send_beat(MODE_CPL, 32'hc3c3_3c3c);
        send_beat(MODE_CPL, 32'h00ff_0000);
        for (int i = 0; i < 5; i++) send_beat(MODE_CPL, 32'h8000_ffff);
        drain_results();
    endtask

    // eight full multifunction slots fill the device limit, the next one overflows
    task automatic test_overflow();
        logic [31:0] d;
        send_beat(MODE_START, $urandom);
        while (scan_phase != SCAN_IDLE) begin
            d = $urandom;
            case (scan_phase)
                SCAN_PROBE, SCAN_ID: if (d[15:0] == VENDOR_ABSENT) d[1] = 1'b0;
                SCAN_HDR0:           d[23] = 1'b1;
                SCAN_HDR:            d[22:16] = 7'h02;
                default: ;
            endcase
            send_beat(MODE_CPL, d);
        end
        send_beat(MODE_CPL, $urandom);
        drain_results();
    endtask

    task automatic test_random_scan();
        int   counted;
        logic mode;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) == 0) quiet_mode = ~quiet_mode;
            if (scan_phase == SCAN_IDLE)
                mode = ($urandom_range(0, 3) != 0) ? MODE_START : MODE_CPL;
            else
                mode = ($urandom_range(0, 99) < RESTART_PCT) ? MODE_START : MODE_CPL;
            if (!(scan_phase == SCAN_IDLE && mode == MODE_CPL)) counted++;
            send_beat(mode, scan_reply(40, NOISE_PCT));
        end
        quiet_mode = 1'b0;
        drain_results();
    endtask

    // receiver side: random stall before each result beat
    initial begin
        int unsigned stall_len;
        i_out_stall = 1'b0;
        forever begin
            stall_len = quiet_mode ? 0 : $urandom_range(0, GAP_MAX);
            repeat (stall_len) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_beat;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected: kind %0d", o_out.kind);
                mismatch_cnt++;
            end else begin
                exp_beat = expected_beats.pop_front();
                check_field("kind", exp_beat.kind, o_out.kind);
                check_field("bus", exp_beat.bus, o_out.bus);
                check_field("slot", exp_beat.slot, o_out.slot);
                check_field("function_res", exp_beat.function_res, o_out.function_res);
                check_field("offset", exp_beat.offset, o_out.offset);
                check_field("vend_id", exp_beat.vend_id, o_out.vend_id);
                check_field("dev_ident", exp_beat.dev_ident, o_out.dev_ident);
                check_field("base_class", exp_beat.base_class, o_out.base_class);
                check_field("subclass", exp_beat.subclass, o_out.subclass);
                check_field("prog_interface", exp_beat.prog_interface, o_out.prog_interface);
                check_field("hdr_byte", exp_beat.hdr_byte, o_out.hdr_byte);
                check_field("bar_value", exp_beat.bar_value, o_out.bar_value);
            end
        end
    end

    // no beat moving on either side for too long means a hang
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_beats.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        quiet_mode   = 1'b0;
        mismatch_cnt = 0;
        idle_cycles  = 0;
        scan_phase   = SCAN_IDLE;
        id_word      = '0;
        class_word   = '0;
        scan_clear();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_completion();
        test_device_walk();
        test_overflow();
        test_random_scan();

        if (expected_beats.size() != 0) begin
            $error("%0d expected results never arrived", expected_beats.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
